// ----- hdl/lats_pkg.sv -----
`default_nettype none

package lats_pkg;

    localparam int OUT_WIDTH     = 49;
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic {
        ACT_STEP = 1'b0,
        ACT_LOAD = 1'b1
    } lats_action_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] board;
        logic                 restarted;
    } lats_result_t;

endpackage

`default_nettype wire

// ----- hdl/life_automaton_torus_step_top.sv -----
`default_nettype none

// channel   direction  handshake             payload
// in        input      in_valid / in_stall   action, fill_pattern
// out       output     out_valid / out_stall board_now, restarted
//
// one item per cycle unless stalled; result held in out/skid reg
// the whole board updates in one pass from the board register
// reset clears the board to all dead and empties the output stages
// a skid register holds one extra result, so input stalls only when
// both the output and skid registers are full

module life_automaton_torus_step_top
    import lats_pkg::*;
#(
    parameter int GRID_SIZE = 7
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 action,
    input  wire logic [OUT_WIDTH-1:0] fill_pattern,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [OUT_WIDTH-1:0] board_now,
    output logic                      restarted
);

    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
    localparam int FILL_BITS  = (CELL_COUNT < OUT_WIDTH) ? CELL_COUNT : OUT_WIDTH;

    logic [CELL_COUNT-1:0] board_reg, board_next;
    logic [CELL_COUNT-1:0] gen_board;
    logic [CELL_COUNT-1:0] fill_cells;
    logic                  in_xfer;
    logic                  stagnant;
    lats_result_t          result;
    lats_result_t          out_reg, out_next;
    lats_result_t          skid_reg, skid_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;

    lats_gen #(
        .GRID_SIZE (GRID_SIZE)
    ) u_gen (
        .board      (board_reg),
        .board_next (gen_board)
    );

    assign in_stall   = skid_valid_reg;
    assign in_xfer    = in_valid && !in_stall;
    assign fill_cells = CELL_COUNT'(fill_pattern[FILL_BITS-1:0]);
    assign stagnant   = (gen_board == board_reg);

    // next board and result for the current input
    always_comb
    begin
        board_next       = board_reg;
        result.restarted = 1'b0;
        if (in_xfer)
        begin
            if (action == ACT_LOAD)
            begin
                board_next = fill_cells;
            end
            else if (stagnant)
            begin
                board_next       = fill_cells;
                result.restarted = 1'b1;
            end
            else
            begin
                board_next = gen_board;
            end
        end
        result.board = OUT_WIDTH'(board_next[FILL_BITS-1:0]);
    end

    // output register with skid stage
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            board_reg      <= board_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign board_now = out_reg.board;
    assign restarted = out_reg.restarted;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_load_board: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (action == ACT_LOAD) |=> board_reg == $past(fill_cells))
        else $error("load did not place fill pattern on board");

    a_step_changes: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (action == ACT_STEP) && !stagnant |=> board_reg != $past(board_reg))
        else $error("non-stagnant step left board unchanged");

    a_xfer_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("accepted item produced no pending result");

endmodule

`default_nettype wire

// ----- hdl/lats_gen.sv -----
`default_nettype none

module lats_gen
    import lats_pkg::*;
#(
    parameter int GRID_SIZE = 7
)
(
    input  wire logic [GRID_SIZE*GRID_SIZE-1:0] board,
    output logic      [GRID_SIZE*GRID_SIZE-1:0] board_next
);

    genvar r, c;

    generate
        for (r = 0; r < GRID_SIZE; r++)
        begin : g_row
            localparam int UP = (r + GRID_SIZE - 1) % GRID_SIZE;
            localparam int DN = (r + 1) % GRID_SIZE;
            for (c = 0; c < GRID_SIZE; c++)
            begin : g_col
                localparam int LF = (c + GRID_SIZE - 1) % GRID_SIZE;
                localparam int RT = (c + 1) % GRID_SIZE;
                logic [3:0] count;

                assign count = 4'(board[UP*GRID_SIZE + LF]) + 4'(board[UP*GRID_SIZE + c])
                             + 4'(board[UP*GRID_SIZE + RT]) + 4'(board[r*GRID_SIZE + LF])
                             + 4'(board[r*GRID_SIZE + RT])  + 4'(board[DN*GRID_SIZE + LF])
                             + 4'(board[DN*GRID_SIZE + c])  + 4'(board[DN*GRID_SIZE + RT]);

                assign board_next[r*GRID_SIZE + c] =
                    (count == 4'(BIRTH_COUNT)) ||
                    (board[r*GRID_SIZE + c] && (count == 4'(SURVIVE_COUNT)));
            end
        end
    endgenerate

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench
    import lats_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID          = 7;
    localparam int CELLS         = GRID * GRID;
    localparam int RANDOM_ITEMS  = 1880;
    localparam int NUM_DIRECTED  = 23;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int HOLD_START    = 400;
    localparam int HOLD_CYCLES   = 80;
    localparam int CALM_RX_START = 1500;
    localparam int CALM_RX_END   = 2200;

    localparam logic [CELLS-1:0] ALL_LIVE   = 49'h1FFFFFFFFFFFF;
    localparam logic [CELLS-1:0] ODD_CELLS  = 49'h0AAAAAAAAAAAA;
    localparam logic [CELLS-1:0] EVEN_CELLS = 49'h1555555555555;
    localparam logic [CELLS-1:0] CORNERS    = 49'h1040000000041;
    localparam logic [CELLS-1:0] BLINKER    = 49'h0000003800000;
    localparam logic [CELLS-1:0] WRAP_BLINK = 49'h0000000000043;
    localparam logic [CELLS-1:0] GLIDER     = 49'h000000001C202;

    typedef struct {
        lats_action_t     act;
        logic [CELLS-1:0] fill;
        bit               typed;
        logic [CELLS-1:0] want_board;
        logic             want_restart;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 action;
    logic [CELLS-1:0]     fill_pattern;
    logic                 out_valid;
    logic                 out_stall;
    logic [CELLS-1:0]     board_now;
    logic                 restarted;

    bit                   row_typed;
    lats_result_t         row_want;
    bit                   sender_calm;
    logic [CELLS-1:0]     live_board;
    lats_result_t         pending_results[$];
    int                   mismatches;
    int                   quiet_cycles;
    directed_row_t        directed_rows[NUM_DIRECTED];

    life_automaton_torus_step_top #(
        .GRID_SIZE(GRID)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .fill_pattern(fill_pattern),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .board_now(board_now),
        .restarted(restarted)
    );

    always
    begin
        #2ns clk = 1'b1;
        #2ns clk = 1'b0;
    end

    function automatic logic [CELLS-1:0] life_next(input logic [CELLS-1:0] b);
        logic [CELLS-1:0] nb;
        int               n;
        int               idx;
        nb = '0;
        for (int r = 0; r < GRID; r++)
        begin
            for (int c = 0; c < GRID; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                        begin
                            n += b[((r + dr + GRID) % GRID) * GRID + (c + dc + GRID) % GRID];
                        end
                    end
                end
                idx = r * GRID + c;
                nb[idx] = (n == BIRTH_COUNT) || (b[idx] && n == SURVIVE_COUNT);
            end
        end
        return nb;
    endfunction

    function automatic logic [CELLS-1:0] rand_cells();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return a[CELLS-1:0];
            1:       return a[CELLS-1:0] & b[CELLS-1:0];
            2:       return a[CELLS-1:0] | b[CELLS-1:0];
            default: return a[CELLS-1:0] & b[CELLS-1:0] & c[CELLS-1:0];
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input lats_action_t act, input logic [CELLS-1:0] fill,
                             input bit typed, input lats_result_t want);
        while (!sender_calm && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        fill_pattern <= fill;
        row_typed    <= typed;
        row_want     <= want;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : track_board
        lats_result_t     predicted;
        lats_result_t     want;
        logic [CELLS-1:0] nb;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted.restarted = 1'b0;
                if (action == ACT_LOAD)
                begin
                    live_board = fill_pattern;
                end
                else
                begin
                    nb = life_next(live_board);
                    if (nb == live_board)
                    begin
                        live_board = fill_pattern;
                        predicted.restarted = 1'b1;
                    end
                    else
                    begin
                        live_board = nb;
                    end
                end
                predicted.board = live_board;
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result expected none actual board %h restarted %b",
                             $time, board_now, restarted);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (board_now !== want.board)
                    begin
                        $display("%0t: board_now expected %h actual %h",
                                 $time, want.board, board_now);
                        mismatches++;
                    end
                    if (restarted !== want.restarted)
                    begin
                        $display("%0t: restarted expected %b actual %b",
                                 $time, want.restarted, restarted);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("life_automaton_torus_step_top: mismatch");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off, one calm stretch
    initial
    begin : receiver
        int cycle;
        out_stall = 1'b0;
        cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
            begin
                out_stall <= 1'b1;
            end
            else if (cycle >= CALM_RX_START && cycle < CALM_RX_END)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 22);
            end
        end
    end

    initial
    begin : sender
        lats_result_t want;
        int           sent;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_STEP;
        fill_pattern = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        sender_calm  = 1'b0;
        live_board   = '0;
        mismatches   = 0;
        quiet_cycles = 0;

        directed_rows = '{
            // empty board after reset is stagnant
            '{ACT_STEP, ALL_LIVE,   1'b1, ALL_LIVE,   1'b1},
            // full board dies out completely
            '{ACT_STEP, '0,         1'b1, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b1, ODD_CELLS,  1'b1},
            '{ACT_LOAD, EVEN_CELLS, 1'b1, EVEN_CELLS, 1'b0},
            '{ACT_STEP, '0,         1'b0, '0,         1'b0},
            // corners form a block across both wraps
            '{ACT_LOAD, CORNERS,    1'b1, CORNERS,    1'b0},
            '{ACT_STEP, ALL_LIVE,   1'b1, ALL_LIVE,   1'b1},
            '{ACT_LOAD, ALL_LIVE,   1'b1, ALL_LIVE,   1'b0},
            '{ACT_LOAD, BLINKER,    1'b1, BLINKER,    1'b0},
            '{ACT_STEP, ALL_LIVE,   1'b0, '0,         1'b0},
            '{ACT_STEP, ALL_LIVE,   1'b0, '0,         1'b0},
            '{ACT_LOAD, WRAP_BLINK, 1'b1, WRAP_BLINK, 1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_LOAD, GLIDER,     1'b1, GLIDER,     1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_STEP, ODD_CELLS,  1'b0, '0,         1'b0},
            '{ACT_LOAD, '0,         1'b1, '0,         1'b0},
            '{ACT_STEP, EVEN_CELLS, 1'b1, EVEN_CELLS, 1'b1}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            want.board     = directed_rows[i].want_board;
            want.restarted = directed_rows[i].want_restart;
            send_item(directed_rows[i].act, directed_rows[i].fill,
                      directed_rows[i].typed, want);
        end

        // mostly a load followed by a run of generations, some loose items
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sender_calm = (sent >= 700 && sent < 1000);
            if ($urandom_range(0, 99) < 85)
            begin
                send_item(ACT_LOAD, rand_cells(), 1'b0, '0);
                sent++;
                repeat ($urandom_range(1, 12))
                begin
                    send_item(ACT_STEP, rand_cells(), 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(lats_action_t'($urandom_range(0, 1)), rand_cells(), 1'b0, '0);
                    sent++;
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("life_automaton_torus_step_top: match");
        end
        else
        begin
            $display("life_automaton_torus_step_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
